/* design/psg_pkg.sv */
// Shared types and constants for the pixel similarity graph.
// No dependencies; the top level, front end and back end use this package.
package psg_pkg;

	localparam int PIX_W = 24;
	localparam int LB_W = 2 * PIX_W;
	localparam int POS_W = 10;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int Q_DEPTH = 4;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [CFG_W-1:0] RST_WIDTH = 11'd64;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd64;
	localparam logic [7:0] RST_LUMA = 8'd48;
	localparam logic [7:0] RST_U = 8'd7;
	localparam logic [7:0] RST_V = 8'd6;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LUMA = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_U = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_V = 3'd4;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	typedef struct packed {
		logic [7:0] y;
		logic [7:0] u;
		logic [7:0] v;
	} pix_t;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} nbr_ok_t;

	typedef struct packed {
		pix_t pix;
		logic emit;
		logic frame_end;
		nbr_ok_t ok;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} op_t;

endpackage

/* design/pixel_similarity_graph.sv */
// Top level of the pixel similarity graph: configuration registers,
// front end, operation queue and back end. Uses psg_pkg, psg_front, psg_fifo and psg_back.
//
// Usage:
//   Slave stream carries YUV pixels in raster order (tuser = 0) or drain
//   ticks (tuser = 1). Master stream carries one neighbour mask per pixel
//   with its row and column; tlast marks the frame's final pixel.
//   The mask of a pixel leaves once the pixel one row below and one column
//   to the right has been transferred; the last width+1 masks of a frame
//   are released by one drain tick each.
//   Throughput: one transfer per clock in and out while the receiver
//   accepts. After the final pixel of a one-row frame the input is held
//   off while one extra queue write is made. A mask released by a
//   transfer passes queue, line-buffer read, compare, mask build and
//   output register. When the receiver stalls, the pipeline holds and
//   the queue fills; the input stalls once the queue is full. No result is lost.
//   Reset restores width 64, height 64 and limits 48/7/6 and restarts the
//   frame position. Writing width or height also restarts the frame.
module pixel_similarity_graph #(
	parameter int MAX_WIDTH = psg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = psg_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [23:0]                     s_axis_tdata,   // luma, chroma_u, chroma_v
	input  logic [0:0]                      s_axis_tuser,   // kind
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,   // neighbour_mask, pixel_row, pixel_col
	output logic                            m_axis_tlast,
	input  logic                            cfg_wen,
	input  logic [psg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psg_pkg::CFG_W-1:0]       cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int QW = CW + $bits(psg_pkg::op_t);

	logic [psg_pkg::CFG_W-1:0] image_width_q, image_height_q;
	logic [7:0] luma_limit_q, u_limit_q, v_limit_q;
	logic restart;
	psg_pkg::pix_t in_pix;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	logic [CW-1:0] fq_addr, bq_addr;
	psg_pkg::op_t fq_op, bq_op;
	logic [QW-1:0] bq_word;

	assign restart = cfg_wen
		&& (cfg_index == psg_pkg::REG_WIDTH || cfg_index == psg_pkg::REG_HEIGHT);
	assign in_pix.y = s_axis_tdata[7:0];
	assign in_pix.u = s_axis_tdata[15:8];
	assign in_pix.v = s_axis_tdata[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= psg_pkg::RST_WIDTH;
			image_height_q <= psg_pkg::RST_HEIGHT;
			luma_limit_q <= psg_pkg::RST_LUMA;
			u_limit_q <= psg_pkg::RST_U;
			v_limit_q <= psg_pkg::RST_V;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				psg_pkg::REG_WIDTH: begin
					image_width_q <= cfg_data;
				end
				psg_pkg::REG_HEIGHT: begin
					image_height_q <= cfg_data;
				end
				psg_pkg::REG_LUMA: begin
					luma_limit_q <= cfg_data[7:0];
				end
				psg_pkg::REG_U: begin
					u_limit_q <= cfg_data[7:0];
				end
				psg_pkg::REG_V: begin
					v_limit_q <= cfg_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	psg_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.image_width(image_width_q),
		.image_height(image_height_q),
		.restart(restart),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_kind(s_axis_tuser[0]),
		.in_pix(in_pix),
		.q_valid(fq_valid),
		.q_ready(fq_ready),
		.q_addr(fq_addr),
		.q_op(fq_op)
	);

	psg_fifo #(
		.WIDTH(QW),
		.DEPTH(psg_pkg::Q_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_data({fq_addr, fq_op}),
		.rd_valid(bq_valid),
		.rd_ready(bq_ready),
		.rd_data(bq_word)
	);

	assign bq_addr = bq_word[QW-1:$bits(psg_pkg::op_t)];
	assign bq_op = psg_pkg::op_t'(bq_word[$bits(psg_pkg::op_t)-1:0]);

	psg_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.luma_limit(luma_limit_q),
		.u_limit(u_limit_q),
		.v_limit(v_limit_q),
		.q_valid(bq_valid),
		.q_ready(bq_ready),
		.q_addr(bq_addr),
		.q_op(bq_op),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata(m_axis_tdata),
		.m_tlast(m_axis_tlast)
	);

endmodule

/* design/psg_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module psg_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/psg_fifo.sv */
// Small synchronous queue between front and back.
// No dependencies.
module psg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] buf_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [NW-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != NW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data = buf_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= wr_data;
		end
	end

endmodule

/* design/psg_front.sv */
// Front end: accepts pixels and drain ticks, tracks frame position and
// mask numbering, and issues window pushes to the queue. Uses psg_pkg.
module psg_front #(
	parameter int MAX_WIDTH = psg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = psg_pkg::DEF_MAX_HEIGHT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [psg_pkg::CFG_W-1:0]     image_width,
	input  logic [psg_pkg::CFG_W-1:0]     image_height,
	input  logic                          restart,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_kind,
	input  psg_pkg::pix_t                 in_pix,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
	output psg_pkg::op_t                  q_op
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int EH = $clog2(MAX_HEIGHT + 1);

	logic [EW-1:0] w_eff;
	logic [EH-1:0] h_eff;
	logic [CW-1:0] wm1, pcol_q, col_now, pcol_next;
	logic [RW-1:0] hm1, in_row_q, row_now;
	logic [CW-1:0] ocol_q;
	logic [RW-1:0] orow_q;
	logic all_in_q, silent_q;
	logic acc, is_pixel, px_emit, out_last, col_last;

	always_comb begin
		if (image_width == '0) begin
			w_eff = EW'(1);
		end else if (int'(image_width) > MAX_WIDTH) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(image_width);
		end
		if (image_height == '0) begin
			h_eff = EH'(1);
		end else if (int'(image_height) > MAX_HEIGHT) begin
			h_eff = EH'(MAX_HEIGHT);
		end else begin
			h_eff = EH'(image_height);
		end
	end

	assign wm1 = CW'(w_eff - EW'(1));
	assign hm1 = RW'(h_eff - EH'(1));
	assign col_now = all_in_q ? '0 : pcol_q;
	assign row_now = all_in_q ? '0 : in_row_q;
	assign col_last = col_now == wm1;
	assign pcol_next = (pcol_q == wm1) ? '0 : pcol_q + 1'b1;
	assign is_pixel = in_kind == psg_pkg::KIND_PIXEL;
	assign in_ready = q_ready && !silent_q;
	assign acc = in_valid && in_ready;
	assign px_emit = (row_now != '0) && !((row_now == RW'(1)) && (col_now == '0));
	assign out_last = (orow_q == hm1) && (ocol_q == wm1);

	always_comb begin
		q_valid = 1'b0;
		q_addr = pcol_q;
		q_op.pix = in_pix;
		q_op.emit = 1'b0;
		q_op.frame_end = out_last;
		q_op.ok.top = orow_q != '0;
		q_op.ok.bottom = orow_q != hm1;
		q_op.ok.left = ocol_q != '0;
		q_op.ok.right = ocol_q != wm1;
		q_op.row = psg_pkg::POS_W'(orow_q);
		q_op.col = psg_pkg::POS_W'(ocol_q);
		if (silent_q) begin
			q_valid = 1'b1;
		end else if (acc && is_pixel) begin
			q_valid = 1'b1;
			q_addr = col_now;
			q_op.emit = px_emit;
		end else if (acc && all_in_q) begin
			q_valid = 1'b1;
			q_op.emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcol_q <= '0;
			in_row_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			all_in_q <= 1'b0;
			silent_q <= 1'b0;
		end else if (restart) begin
			pcol_q <= '0;
			in_row_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			all_in_q <= 1'b0;
			silent_q <= 1'b0;
		end else if (silent_q) begin
			if (q_ready) begin
				silent_q <= 1'b0;
				pcol_q <= pcol_next;
			end
		end else if (acc && is_pixel) begin
			pcol_q <= col_last ? '0 : col_now + 1'b1;
			if (all_in_q) begin
				all_in_q <= 1'b0;
				ocol_q <= '0;
				orow_q <= '0;
			end
			if (col_last) begin
				if (row_now == hm1) begin
					in_row_q <= '0;
					all_in_q <= 1'b1;
					silent_q <= hm1 == '0;
				end else begin
					in_row_q <= row_now + 1'b1;
				end
			end
			if (px_emit) begin
				if (ocol_q == wm1) begin
					ocol_q <= '0;
					orow_q <= orow_q + 1'b1;
				end else begin
					ocol_q <= ocol_q + 1'b1;
				end
			end
		end else if (acc && all_in_q) begin
			if (out_last) begin
				all_in_q <= 1'b0;
				ocol_q <= '0;
				orow_q <= '0;
				pcol_q <= '0;
			end else begin
				pcol_q <= pcol_next;
				if (ocol_q == wm1) begin
					ocol_q <= '0;
					orow_q <= orow_q + 1'b1;
				end else begin
					ocol_q <= ocol_q + 1'b1;
				end
			end
		end
	end

endmodule

/* design/psg_back.sv */
// Back end: two-row line buffer, 3x3 window, similarity compare and mask
// build, output register. Uses psg_pkg and psg_ram.
module psg_back #(
	parameter int MAX_WIDTH = psg_pkg::DEF_MAX_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [7:0]                   luma_limit,
	input  logic [7:0]                   u_limit,
	input  logic [7:0]                   v_limit,
	input  logic                         q_valid,
	output logic                         q_ready,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_addr,
	input  psg_pkg::op_t                 q_op,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,
	output logic                         m_tlast
);

	localparam int CW = $clog2(MAX_WIDTH);

	typedef struct packed {
		logic t, tr, r, br, b, bl, l, tl;
		logic tl_t, tl_l, t_tr, tr_r, l_bl, bl_b, b_br, r_br;
	} sims_t;

	function automatic logic similar(psg_pkg::pix_t a, psg_pkg::pix_t b,
		logic [7:0] ly, logic [7:0] lu, logic [7:0] lv);
		logic [7:0] dy, du, dv;
		dy = (a.y > b.y) ? a.y - b.y : b.y - a.y;
		du = (a.u > b.u) ? a.u - b.u : b.u - a.u;
		dv = (a.v > b.v) ? a.v - b.v : b.v - a.v;
		return (dy < ly) && (du < lu) && (dv < lv);
	endfunction

	logic adv, wr_en;
	logic valid_s1, valid_s2, valid_s3, fwd_s1;
	logic [CW-1:0] addr_s1;
	psg_pkg::op_t op_s1, op_s2, op_s3;
	logic [psg_pkg::LB_W-1:0] ram_rdata, rd_word, wr_word, last_wr_q;
	psg_pkg::pix_t rd_old, rd_new;
	psg_pkg::pix_t win_q [3][3];
	sims_t sim, sim_s3;
	logic blk_tl, blk_tr, blk_bl, blk_br;
	logic [7:0] mask;
	logic out_valid_q;
	logic [7:0] mask_q;
	logic [psg_pkg::POS_W-1:0] row_q, col_q;
	logic last_q;

	assign adv = !out_valid_q || m_tready;
	assign q_ready = adv;
	assign wr_en = adv && valid_s1;
	assign rd_word = fwd_s1 ? last_wr_q : ram_rdata;
	assign rd_old = psg_pkg::pix_t'(rd_word[psg_pkg::LB_W-1:psg_pkg::PIX_W]);
	assign rd_new = psg_pkg::pix_t'(rd_word[psg_pkg::PIX_W-1:0]);
	assign wr_word = {rd_new, op_s1.pix};

	psg_ram #(
		.WIDTH(psg_pkg::LB_W),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk(clk),
		.we(wr_en),
		.waddr(addr_s1),
		.wdata(wr_word),
		.re(adv),
		.raddr(q_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			fwd_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			fwd_s1 <= valid_s1 && (q_addr == addr_s1);
			out_valid_q <= valid_s3 && op_s3.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_wr_q <= wr_word;
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2][0] <= rd_old;
			win_q[2][1] <= rd_new;
			win_q[2][2] <= op_s1.pix;
		end
		if (adv) begin
			addr_s1 <= q_addr;
			op_s1 <= q_op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			sim_s3 <= sim;
			mask_q <= mask;
			row_q <= op_s3.row;
			col_q <= op_s3.col;
			last_q <= op_s3.frame_end;
		end
	end

	always_comb begin
		sim.t = similar(win_q[1][1], win_q[1][0], luma_limit, u_limit, v_limit);
		sim.tr = similar(win_q[1][1], win_q[2][0], luma_limit, u_limit, v_limit);
		sim.r = similar(win_q[1][1], win_q[2][1], luma_limit, u_limit, v_limit);
		sim.br = similar(win_q[1][1], win_q[2][2], luma_limit, u_limit, v_limit);
		sim.b = similar(win_q[1][1], win_q[1][2], luma_limit, u_limit, v_limit);
		sim.bl = similar(win_q[1][1], win_q[0][2], luma_limit, u_limit, v_limit);
		sim.l = similar(win_q[1][1], win_q[0][1], luma_limit, u_limit, v_limit);
		sim.tl = similar(win_q[1][1], win_q[0][0], luma_limit, u_limit, v_limit);
		sim.tl_t = similar(win_q[0][0], win_q[1][0], luma_limit, u_limit, v_limit);
		sim.tl_l = similar(win_q[0][0], win_q[0][1], luma_limit, u_limit, v_limit);
		sim.t_tr = similar(win_q[1][0], win_q[2][0], luma_limit, u_limit, v_limit);
		sim.tr_r = similar(win_q[2][0], win_q[2][1], luma_limit, u_limit, v_limit);
		sim.l_bl = similar(win_q[0][1], win_q[0][2], luma_limit, u_limit, v_limit);
		sim.bl_b = similar(win_q[0][2], win_q[1][2], luma_limit, u_limit, v_limit);
		sim.b_br = similar(win_q[1][2], win_q[2][2], luma_limit, u_limit, v_limit);
		sim.r_br = similar(win_q[2][1], win_q[2][2], luma_limit, u_limit, v_limit);
	end

	always_comb begin
		blk_tl = op_s3.ok.top && op_s3.ok.left && sim_s3.tl_t && sim_s3.tl_l
			&& sim_s3.t && sim_s3.l;
		blk_tr = op_s3.ok.top && op_s3.ok.right && sim_s3.t_tr && sim_s3.tr_r
			&& sim_s3.t && sim_s3.r;
		blk_bl = op_s3.ok.bottom && op_s3.ok.left && sim_s3.l_bl && sim_s3.bl_b
			&& sim_s3.l && sim_s3.b;
		blk_br = op_s3.ok.bottom && op_s3.ok.right && sim_s3.b_br && sim_s3.r_br
			&& sim_s3.r && sim_s3.b;
		mask[0] = op_s3.ok.top && sim_s3.t;
		mask[1] = op_s3.ok.top && op_s3.ok.right && sim_s3.tr && !blk_tr;
		mask[2] = op_s3.ok.right && sim_s3.r;
		mask[3] = op_s3.ok.bottom && op_s3.ok.right && sim_s3.br && !blk_br;
		mask[4] = op_s3.ok.bottom && sim_s3.b;
		mask[5] = op_s3.ok.bottom && op_s3.ok.left && sim_s3.bl && !blk_bl;
		mask[6] = op_s3.ok.left && sim_s3.l;
		mask[7] = op_s3.ok.top && op_s3.ok.left && sim_s3.tl && !blk_tl;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'b0000, col_q, row_q, mask_q};
	assign m_tlast = last_q;

endmodule
